// ===== rtl/rict_pkg.sv =====
// Shared constants, types and codes for the reference-counted lookup cache.
package rict_pkg;

  localparam int CACHE_ENTRIES = 32;
  localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int NUM_W         = 16;
  localparam int REF_W         = 8;
  localparam int SLOT_W        = 5;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
  localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_DUP     = 2'd1,
    FN_RELEASE = 2'd2,
    FN_MARK    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_REF = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_UPDATE
  } back_state_e;

  // Decoded item as it sits in the queue
  typedef struct packed {
    func_e             func;
    logic [NUM_W-1:0]  number;
    logic [SLOT_W-1:0] slot;
    logic              links_zero;
    logic              slot_oob;
  } cmd_t;

  // Queue head handshake towards the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== rtl/rict_front.sv =====
// Front end: decodes accepted items and queues them for the back end.
module rict_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [rict_pkg::NUM_W-1:0]    object_number_i,
  input  logic [rict_pkg::SLOT_W-1:0]   slot_in_i,
  input  logic                          links_zero_i,
  output rict_pkg::queue_head_t         head_o,
  input  logic                          pop_i
);

  rict_pkg::cmd_t                    queue_q [rict_pkg::QUEUE_DEPTH];
  logic [rict_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rict_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rict_pkg::QCNT_W-1:0]       count_q, count_d;
  rict_pkg::cmd_t                    cmd_in;
  logic                              push;
  logic                              pop;

  // Slot range check done once, here, so the back end only sees a flag
  always_comb begin
    cmd_in.func       = rict_pkg::func_e'(func_i);
    cmd_in.number     = object_number_i;
    cmd_in.slot       = slot_in_i;
    cmd_in.links_zero = links_zero_i;
    cmd_in.slot_oob   = (32'(slot_in_i) >= 32'(rict_pkg::CACHE_ENTRIES));
  end

  assign in_ready_o = (count_q != rict_pkg::QCNT_W'(rict_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == rict_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == rict_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/rict_back.sv =====
// Back end: associative lookup, entry update and the result register.
module rict_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rict_pkg::queue_head_t         head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rict_pkg::SLOT_W-1:0]   slot_out_o,
  output logic                          hit_o,
  output logic                          loaded_o,
  output logic [rict_pkg::REF_W-1:0]    ref_count_o,
  output logic                          destroy_needed_o,
  output logic [1:0]                    status_o
);

  localparam int N = rict_pkg::CACHE_ENTRIES;

  // Table storage; an entry is free when its count is zero
  logic [rict_pkg::NUM_W-1:0] number_q [N];
  logic [rict_pkg::REF_W-1:0] refs_q   [N];
  logic                       loaded_q [N];

  rict_pkg::back_state_e      state_q, state_d;
  rict_pkg::cmd_t             cmd_q;

  // Lookup stage results
  logic                       hit_q, hit_d;
  logic                       free_q, free_d;
  logic [rict_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [rict_pkg::IDX_W-1:0] free_idx_q, free_idx_d;

  // Result register
  logic                        res_valid_q, res_valid_d;
  logic [rict_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic                        res_hit_q, res_hit_d;
  logic                        res_loaded_q, res_loaded_d;
  logic [rict_pkg::REF_W-1:0]  res_refs_q, res_refs_d;
  logic                        res_destroy_q, res_destroy_d;
  rict_pkg::status_e           res_status_q, res_status_d;

  // Table write port
  logic                        wr_en;
  logic                        wr_num_en;
  logic [rict_pkg::IDX_W-1:0]  wr_idx;
  logic [rict_pkg::REF_W-1:0]  wr_refs;
  logic                        wr_loaded;

  logic                        res_free;
  logic                        do_update;
  logic                        load_cmd;
  logic [rict_pkg::IDX_W-1:0]  sel_idx;
  logic [rict_pkg::REF_W-1:0]  sel_refs;
  logic                        sel_loaded;
  logic                        destroy;

  assign res_free  = !res_valid_q || out_ready_i;
  assign do_update = (state_q == rict_pkg::BK_UPDATE) && res_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rict_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          state_d = rict_pkg::BK_LOOKUP;
        end
      end
      rict_pkg::BK_LOOKUP: begin
        state_d = rict_pkg::BK_UPDATE;
      end
      rict_pkg::BK_UPDATE: begin
        if (res_free) begin
          state_d = head_i.valid ? rict_pkg::BK_LOOKUP : rict_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rict_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load_cmd = 1'b0;
    unique case (state_q)
      rict_pkg::BK_IDLE:   load_cmd = head_i.valid;
      rict_pkg::BK_LOOKUP: load_cmd = 1'b0;
      rict_pkg::BK_UPDATE: load_cmd = res_free && head_i.valid;
      default:             load_cmd = 1'b0;
    endcase
  end
  assign pop_o = load_cmd;

  // Parallel compare across all entries, lowest index wins
  always_comb begin
    hit_d      = 1'b0;
    free_d     = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if ((refs_q[i] != '0) && (cmd_q.number != '0) && (number_q[i] == cmd_q.number)) begin
        hit_d     = 1'b1;
        hit_idx_d = rict_pkg::IDX_W'(i);
      end
      if (refs_q[i] == '0) begin
        free_d     = 1'b1;
        free_idx_d = rict_pkg::IDX_W'(i);
      end
    end
  end

  // Update stage
  always_comb begin
    if (cmd_q.func == rict_pkg::FN_GET) begin
      sel_idx = hit_q ? hit_idx_q : free_idx_q;
    end else begin
      sel_idx = rict_pkg::IDX_W'(cmd_q.slot);
    end
    sel_refs   = refs_q[sel_idx];
    sel_loaded = loaded_q[sel_idx];
    destroy    = (sel_refs == rict_pkg::REF_ONE) && sel_loaded && cmd_q.links_zero;

    wr_en         = 1'b0;
    wr_num_en     = 1'b0;
    wr_idx        = sel_idx;
    wr_refs       = sel_refs;
    wr_loaded     = sel_loaded;
    res_slot_d    = cmd_q.slot;
    res_hit_d     = 1'b0;
    res_loaded_d  = 1'b0;
    res_refs_d    = '0;
    res_destroy_d = 1'b0;
    res_status_d  = rict_pkg::ST_OK;

    if (cmd_q.func == rict_pkg::FN_GET) begin
      priority if (hit_q) begin
        wr_en        = 1'b1;
        wr_refs      = (sel_refs == rict_pkg::REF_MAX) ? sel_refs : sel_refs + 1'b1;
        res_slot_d   = rict_pkg::SLOT_W'(sel_idx);
        res_hit_d    = 1'b1;
        res_loaded_d = sel_loaded;
        res_refs_d   = wr_refs;
      end else if (free_q) begin
        wr_en        = 1'b1;
        wr_num_en    = 1'b1;
        wr_refs      = rict_pkg::REF_ONE;
        wr_loaded    = 1'b0;
        res_slot_d   = rict_pkg::SLOT_W'(sel_idx);
        res_refs_d   = rict_pkg::REF_ONE;
      end else begin
        res_slot_d   = '0;
        res_status_d = rict_pkg::ST_FULL;
      end
    end else if (cmd_q.slot_oob) begin
      res_status_d = rict_pkg::ST_ZERO_REF;
    end else if (sel_refs == '0) begin
      res_loaded_d = sel_loaded;
      res_status_d = rict_pkg::ST_ZERO_REF;
    end else begin
      wr_en = 1'b1;
      unique case (cmd_q.func)
        rict_pkg::FN_DUP: begin
          wr_refs = (sel_refs == rict_pkg::REF_MAX) ? sel_refs : sel_refs + 1'b1;
        end
        rict_pkg::FN_RELEASE: begin
          wr_refs       = sel_refs - 1'b1;
          wr_loaded     = destroy ? 1'b0 : sel_loaded;
          res_destroy_d = destroy;
        end
        rict_pkg::FN_MARK: begin
          wr_loaded = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
      res_loaded_d = wr_loaded;
      res_refs_d   = wr_refs;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (do_update) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rict_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        refs_q[i]   <= '0;
        loaded_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (do_update && wr_en) begin
        refs_q[wr_idx]   <= wr_refs;
        loaded_q[wr_idx] <= wr_loaded;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update && wr_num_en) begin
      number_q[wr_idx] <= cmd_q.number;
    end
    if (load_cmd) begin
      cmd_q <= head_i.cmd;
    end
    if (state_q == rict_pkg::BK_LOOKUP) begin
      hit_q      <= hit_d;
      free_q     <= free_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
    if (do_update) begin
      res_slot_q    <= res_slot_d;
      res_hit_q     <= res_hit_d;
      res_loaded_q  <= res_loaded_d;
      res_refs_q    <= res_refs_d;
      res_destroy_q <= res_destroy_d;
      res_status_q  <= res_status_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign slot_out_o       = res_slot_q;
  assign hit_o            = res_hit_q;
  assign loaded_o         = res_loaded_q;
  assign ref_count_o      = res_refs_q;
  assign destroy_needed_o = res_destroy_q;
  assign status_o         = res_status_q;

endmodule

// ===== rtl/refcounted_inode_cache_table_top.sv =====
// Top level of the reference-counted lookup cache: front queue plus back end.
//
// Reference-counted lookup cache. A fully associative table of
// rict_pkg::CACHE_ENTRIES entries, each holding an object number, an 8-bit
// saturating reference count and a loaded flag; an entry is free when its
// count is zero. Every item gives exactly one result item. Accepted items go
// into a two-item queue in the front end, so the input side keeps taking
// items while a result waits at the output, until the queue is full. The back
// end handles one item at a time: a lookup state for the parallel number
// compare across all entries with the lowest-index hit and free-entry
// search, then an update state that updates the addressed entry and loads the
// result register, and that waits while a stalled result is held. Reset
// clears all counts and flags at once; no clearing pass.
module refcounted_inode_cache_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [rict_pkg::NUM_W-1:0]    object_number_i,
  input  logic [rict_pkg::SLOT_W-1:0]   slot_in_i,
  input  logic                          links_zero_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rict_pkg::SLOT_W-1:0]   slot_out_o,
  output logic                          hit_o,
  output logic                          loaded_o,
  output logic [rict_pkg::REF_W-1:0]    ref_count_o,
  output logic                          destroy_needed_o,
  output logic [1:0]                    status_o
);

  rict_pkg::queue_head_t head;
  logic                  pop;

  // Decode and buffer
  rict_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .object_number_i(object_number_i),
    .slot_in_i      (slot_in_i),
    .links_zero_i   (links_zero_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  // Lookup, update and result register
  rict_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_out_o      (slot_out_o),
    .hit_o           (hit_o),
    .loaded_o        (loaded_o),
    .ref_count_o     (ref_count_o),
    .destroy_needed_o(destroy_needed_o),
    .status_o        (status_o)
  );

endmodule

// ===== rtl/rict_checker.sv =====
// Port-level checks for the lookup cache, bound to the top level.
module rict_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rict_pkg::SLOT_W-1:0]   slot_out_i,
  input logic                          hit_i,
  input logic                          loaded_i,
  input logic [rict_pkg::REF_W-1:0]    ref_count_i,
  input logic                          destroy_needed_i,
  input logic [1:0]                    status_i
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slot_out_i) &&
      $stable(ref_count_i) && $stable(status_i) && $stable(loaded_i))
    else $error("result changed while stalled");

  // Full table answers all zeros
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == rict_pkg::ST_FULL) |->
      (slot_out_i == '0) && !hit_i && !loaded_i && (ref_count_i == '0) &&
      !destroy_needed_i)
    else $error("table full result not cleared");

  // A hit always leaves a live entry
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> (status_i == rict_pkg::ST_OK) && (ref_count_i != '0) &&
      !destroy_needed_i)
    else $error("hit on a dead entry");

  // Destroy only on the last reference, flag cleared
  a_destroy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && destroy_needed_i |-> (status_i == rict_pkg::ST_OK) &&
      (ref_count_i == '0) && !loaded_i && !hit_i)
    else $error("destroy with references left");

endmodule

bind refcounted_inode_cache_table_top rict_checker u_rict_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .slot_out_i      (slot_out_o),
  .hit_i           (hit_o),
  .loaded_i        (loaded_o),
  .ref_count_i     (ref_count_o),
  .destroy_needed_i(destroy_needed_o),
  .status_i        (status_o)
);
